// ----- rtl/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Shared codes and types for the payload power sequencer.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int StateW = 3;
	localparam int AddrW  = 2;
	localparam int DataW  = 32;

	// sequencer state codes
	localparam logic [StateW-1:0] ST_NONE  = 3'd0;
	localparam logic [StateW-1:0] ST_WAIT  = 3'd1;
	localparam logic [StateW-1:0] ST_SETUP = 3'd2;
	localparam logic [StateW-1:0] ST_ON    = 3'd3;
	localparam logic [StateW-1:0] ST_OFF   = 3'd4;
	localparam logic [StateW-1:0] ST_QUIET = 3'd5;
	localparam logic [StateW-1:0] ST_RESET = 3'd6;

	// register byte addresses
	localparam logic [AddrW-1:0] REG_SETUP_NEEDS_CLOCK_OK = 2'd0;

	typedef struct packed {
		logic payload_power_good;
		logic converters_good;
		logic cold_reset_event;
		logic warm_reset_event;
		logic quiesce_event;
		logic clock_setup_ok;
	} tick_t;

	typedef struct packed {
		logic [StateW-1:0] power_state;
		logic              converter_enable;
		logic              clear_backend_faults;
		logic              fpga_reset_pulse;
		logic              quiesced_notify;
	} result_t;

	typedef struct packed {
		logic [StateW-1:0] state;
		logic              quiesce_pending;
		logic              enable_level;
	} seq_state_t;

endpackage

// ----- rtl/payload_power_sequencer.sv -----
// ----------------------------------------------------------------------------
// payload_power_sequencer
// Tick-driven payload power sequencer with APB-style configuration.
// ----------------------------------------------------------------------------
// Takes one tick transaction per clock cycle unless stalled and returns one
// result per tick. The tick is captured in an input register when accepted.
// When the result register can take it, the combinational state machine
// update lands in the result register together with the sequencer state,
// and the result is presented from there. A stalled result holds the input
// stage; the input side is stalled only while both stages are full and the
// result is stalled.
// The single register (setup_needs_clock_ok, byte address 0, reset 1) should
// be written while no tick is in flight.
// ----------------------------------------------------------------------------
module payload_power_sequencer
	import pps_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [AddrW-1:0]    paddr,
	input  logic [DataW-1:0]    pwdata,
	output logic [DataW-1:0]    prdata,
	output logic                pready,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                payload_power_good,
	input  logic                converters_good,
	input  logic                cold_reset_event,
	input  logic                warm_reset_event,
	input  logic                quiesce_event,
	input  logic                clock_setup_ok,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [StateW-1:0]   power_state,
	output logic                converter_enable,
	output logic                clear_backend_faults,
	output logic                fpga_reset_pulse,
	output logic                quiesced_notify
);

	logic       setup_needs_clock_ok;
	logic       valid_s1;
	tick_t      tick_s1;
	logic       res_valid_q;
	result_t    res_q;
	seq_state_t seq_q;
	seq_state_t seq_nxt;
	result_t    res_nxt;
	logic       accept;
	logic       advance;

	pps_regs u_regs (
		.clk                  (clk),
		.arst_n               (arst_n),
		.psel                 (psel),
		.penable              (penable),
		.pwrite               (pwrite),
		.paddr                (paddr),
		.pwdata               (pwdata),
		.prdata               (prdata),
		.pready               (pready),
		.setup_needs_clock_ok (setup_needs_clock_ok)
	);

	pps_step u_step (
		.tick                 (tick_s1),
		.cur                  (seq_q),
		.setup_needs_clock_ok (setup_needs_clock_ok),
		.nxt                  (seq_nxt),
		.res                  (res_nxt)
	);

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1.payload_power_good <= payload_power_good;
			tick_s1.converters_good    <= converters_good;
			tick_s1.cold_reset_event   <= cold_reset_event;
			tick_s1.warm_reset_event   <= warm_reset_event;
			tick_s1.quiesce_event      <= quiesce_event;
			tick_s1.clock_setup_ok     <= clock_setup_ok;
		end
	end

	// sequencer state advances only when a tick moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q.state           <= ST_NONE;
			seq_q.quiesce_pending <= 1'b0;
			seq_q.enable_level    <= 1'b0;
			res_valid_q           <= 1'b0;
		end else begin
			if (advance) begin
				seq_q       <= seq_nxt;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid            = res_valid_q;
	assign power_state          = res_q.power_state;
	assign converter_enable     = res_q.converter_enable;
	assign clear_backend_faults = res_q.clear_backend_faults;
	assign fpga_reset_pulse     = res_q.fpga_reset_pulse;
	assign quiesced_notify      = res_q.quiesced_notify;

	// the reset state is always left within the tick that enters it
	a_no_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.power_state != ST_RESET))
		else $error("reset state reported");

	a_notify_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.quiesced_notify) |->
			(res_q.power_state == ST_QUIET && !res_q.converter_enable))
		else $error("quiesced notify outside quiesced state");

	a_clear_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.clear_backend_faults) |-> res_q.converter_enable)
		else $error("fault clear without converter enable");

	a_state_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (seq_q.state == res_q.power_state
			&& seq_q.enable_level == res_q.converter_enable))
		else $error("held state differs from reported result");

endmodule

// ----- rtl/pps_regs.sv -----
// ----------------------------------------------------------------------------
// pps_regs
// APB-style configuration register file for the power sequencer.
// ----------------------------------------------------------------------------
module pps_regs
	import pps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output logic             setup_needs_clock_ok
);

	logic setup_needs_clock_ok_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == REG_SETUP_NEEDS_CLOCK_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_needs_clock_ok_q <= 1'b1;
		end else if (wr_en) begin
			setup_needs_clock_ok_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_SETUP_NEEDS_CLOCK_OK) begin
			prdata[0] = setup_needs_clock_ok_q;
		end
	end

	assign setup_needs_clock_ok = setup_needs_clock_ok_q;

endmodule

// ----- rtl/pps_step.sv -----
// ----------------------------------------------------------------------------
// pps_step
// Next-state and pulse logic for one tick of the power sequencer.
// ----------------------------------------------------------------------------
module pps_step
	import pps_pkg::*;
(
	input  tick_t      tick,
	input  seq_state_t cur,
	input  logic       setup_needs_clock_ok,
	output seq_state_t nxt,
	output result_t    res
);

	logic [StateW-1:0] st;
	logic              pending;
	logic              enable;
	logic              clr;
	logic              notify;
	logic [StateW-1:0] next_st;

	always_comb begin
		// cold reset overrides whatever state we were in
		st      = tick.cold_reset_event ? ST_RESET : cur.state;
		pending = cur.quiesce_pending || tick.quiesce_event;
		enable  = cur.enable_level;
		clr     = 1'b0;
		notify  = 1'b0;
		next_st = st;
		case (st)
			ST_NONE: begin
				if (tick.payload_power_good) next_st = ST_WAIT;
			end
			ST_WAIT: begin
				enable = 1'b1;
				clr    = 1'b1;
				if (pending || !tick.payload_power_good) next_st = ST_OFF;
				else if (tick.converters_good) next_st = ST_SETUP;
			end
			ST_SETUP: begin
				if (tick.clock_setup_ok || !setup_needs_clock_ok) next_st = ST_ON;
			end
			ST_ON: begin
				if (pending || !tick.payload_power_good || !tick.converters_good)
					next_st = ST_OFF;
			end
			ST_OFF: begin
				enable = 1'b0;
				// answer a pending quiesce and drop it
				if (pending) begin
					notify  = 1'b1;
					pending = 1'b0;
				end
				next_st = ST_QUIET;
			end
			ST_QUIET: begin
				if (!tick.payload_power_good && !tick.converters_good) next_st = ST_NONE;
			end
			ST_RESET: begin
				enable  = 1'b0;
				next_st = ST_NONE;
			end
			default: begin
				next_st = st;
			end
		endcase

		nxt.state           = next_st;
		nxt.quiesce_pending = pending;
		nxt.enable_level    = enable;

		res.power_state          = next_st;
		res.converter_enable     = enable;
		res.clear_backend_faults = clr;
		res.fpga_reset_pulse     = tick.warm_reset_event;
		res.quiesced_notify      = notify;
	end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the payload power sequencer.
// ----------------------------------------------------------------------------
// Ticks go in through a valid/stall channel and results come back through
// another. A behavioural copy of the sequencer runs beside the block and
// predicts one result per accepted tick. A short table of directed ticks
// walks the state machine first. Random ticks with slowly changing power
// levels and occasional noise follow. The setup clock rule register is
// toggled between phases, and the idling of both sides varies per phase.
// ----------------------------------------------------------------------------
module testbench
	import pps_pkg::*;
();

	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_TICKS = 6;
	localparam int RANDOM_TICKS = 100;

	typedef struct packed {
		tick_t   tick;
		logic    typed;
		result_t want;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [AddrW-1:0]  paddr;
	logic [DataW-1:0]  pwdata;
	logic [DataW-1:0]  prdata;
	logic              pready;
	logic              req_valid;
	logic              req_stall;
	logic              payload_power_good;
	logic              converters_good;
	logic              cold_reset_event;
	logic              warm_reset_event;
	logic              quiesce_event;
	logic              clock_setup_ok;
	logic              res_valid;
	logic              res_stall;
	logic [StateW-1:0] power_state;
	logic              converter_enable;
	logic              clear_backend_faults;
	logic              fpga_reset_pulse;
	logic              quiesced_notify;

	// sequencer copy kept by the bench
	logic [StateW-1:0] seq_state;
	logic              quiesce_held;
	logic              enable_held;
	logic              clock_rule;

	result_t outcome_q[$];
	int      mismatch_count = 0;
	int      outcome_count = 0;
	int      cycle_count = 0;
	int      send_idle_pct;
	int      recv_idle_pct;
	logic    pg_level;
	logic    dcdc_level;

	// tick bits: pg, dcdc, cold, warm, quiesce, clk_ok
	// typed result bits after the state: enable, clear, fpga reset, notify
	plan_row_t directed_plan [0:26] = '{
		'{6'b000000, 1'b1, {ST_NONE,  4'b0000}},
		'{6'b100000, 1'b1, {ST_WAIT,  4'b0000}},
		'{6'b100000, 1'b1, {ST_WAIT,  4'b1100}},
		'{6'b110000, 1'b1, {ST_SETUP, 4'b1100}},
		'{6'b110000, 1'b1, {ST_SETUP, 4'b1000}},
		'{6'b110001, 1'b1, {ST_ON,    4'b1000}},
		'{6'b110100, 1'b1, {ST_ON,    4'b1010}},
		'{6'b110010, 1'b1, {ST_OFF,   4'b1000}},
		'{6'b110000, 1'b1, {ST_QUIET, 4'b0001}},
		'{6'b100000, 1'b1, {ST_QUIET, 4'b0000}},
		'{6'b000000, 1'b1, {ST_NONE,  4'b0000}},
		'{6'b100000, 1'b1, {ST_WAIT,  4'b0000}},
		'{6'b000000, 1'b1, {ST_OFF,   4'b1100}},
		'{6'b000000, 1'b1, {ST_QUIET, 4'b0000}},
		'{6'b010000, 1'b1, {ST_QUIET, 4'b0000}},
		'{6'b000000, 1'b1, {ST_NONE,  4'b0000}},
		'{6'b100010, 1'b1, {ST_WAIT,  4'b0000}},
		'{6'b110000, 1'b1, {ST_OFF,   4'b1100}},
		'{6'b110000, 1'b1, {ST_QUIET, 4'b0001}},
		'{6'b111111, 1'b1, {ST_NONE,  4'b0010}},
		'{6'b110001, 1'b0, 7'd0},
		'{6'b110001, 1'b0, 7'd0},
		'{6'b110001, 1'b0, 7'd0},
		'{6'b000000, 1'b0, 7'd0},
		'{6'b110000, 1'b0, 7'd0},
		'{6'b110000, 1'b0, 7'd0},
		'{6'b111001, 1'b1, {ST_NONE,  4'b0000}}
	};

	payload_power_sequencer dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.psel                 (psel),
		.penable              (penable),
		.pwrite               (pwrite),
		.paddr                (paddr),
		.pwdata               (pwdata),
		.prdata               (prdata),
		.pready               (pready),
		.req_valid            (req_valid),
		.req_stall            (req_stall),
		.payload_power_good   (payload_power_good),
		.converters_good      (converters_good),
		.cold_reset_event     (cold_reset_event),
		.warm_reset_event     (warm_reset_event),
		.quiesce_event        (quiesce_event),
		.clock_setup_ok       (clock_setup_ok),
		.res_valid            (res_valid),
		.res_stall            (res_stall),
		.power_state          (power_state),
		.converter_enable     (converter_enable),
		.clear_backend_faults (clear_backend_faults),
		.fpga_reset_pulse     (fpga_reset_pulse),
		.quiesced_notify      (quiesced_notify)
	);

	always #5 clk = ~clk;

	// Step the bench copy of the sequencer by one tick and return its outcome.
	function automatic result_t advance_sequencer(input tick_t t);
		result_t           r;
		logic [StateW-1:0] cur;
		logic [StateW-1:0] nxt;
		r = '0;
		cur = seq_state;
		if (t.cold_reset_event)
			cur = ST_RESET;
		if (t.warm_reset_event)
			r.fpga_reset_pulse = 1'b1;
		if (t.quiesce_event)
			quiesce_held = 1'b1;
		nxt = cur;
		case (cur)
			ST_NONE: begin
				if (t.payload_power_good)
					nxt = ST_WAIT;
			end
			ST_WAIT: begin
				enable_held = 1'b1;
				r.clear_backend_faults = 1'b1;
				if (quiesce_held || !t.payload_power_good)
					nxt = ST_OFF;
				else if (t.converters_good)
					nxt = ST_SETUP;
			end
			ST_SETUP: begin
				if (t.clock_setup_ok || !clock_rule)
					nxt = ST_ON;
			end
			ST_ON: begin
				if (quiesce_held || !t.payload_power_good || !t.converters_good)
					nxt = ST_OFF;
			end
			ST_OFF: begin
				enable_held = 1'b0;
				if (quiesce_held) begin
					r.quiesced_notify = 1'b1;
					quiesce_held = 1'b0;
				end
				nxt = ST_QUIET;
			end
			ST_QUIET: begin
				if (!t.payload_power_good && !t.converters_good)
					nxt = ST_NONE;
			end
			ST_RESET: begin
				enable_held = 1'b0;
				nxt = ST_NONE;
			end
			default: ;
		endcase
		seq_state = nxt;
		r.power_state = nxt;
		r.converter_enable = enable_held;
		return r;
	endfunction

	// Mostly slow-moving power levels with sparse events, some pure noise.
	function automatic tick_t random_tick();
		tick_t t;
		if ($urandom_range(0, 9) == 0) begin
			t = tick_t'($bits(tick_t)'($urandom));
		end else begin
			if ($urandom_range(0, 9) == 0)
				pg_level = ~pg_level;
			if ($urandom_range(0, 7) == 0)
				dcdc_level = ~dcdc_level;
			t.payload_power_good = pg_level;
			t.converters_good    = dcdc_level;
			t.cold_reset_event   = ($urandom_range(0, 24) == 0);
			t.warm_reset_event   = ($urandom_range(0, 7) == 0);
			t.quiesce_event      = ($urandom_range(0, 9) == 0);
			t.clock_setup_ok     = 1'($urandom_range(0, 1));
		end
		return t;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("mismatch on result %0d: %s got %0d, expected %0d",
			outcome_count, what, got, want);
	endtask

	task automatic send_tick(input tick_t t, input logic typed, input result_t want);
		result_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		payload_power_good <= t.payload_power_good;
		converters_good    <= t.converters_good;
		cold_reset_event   <= t.cold_reset_event;
		warm_reset_event   <= t.warm_reset_event;
		quiesce_event      <= t.quiesce_event;
		clock_setup_ok     <= t.clock_setup_ok;
		req_valid          <= 1'b1;
		do @(posedge clk); while (req_stall);
		predicted = advance_sequencer(t);
		outcome_q.push_back(typed ? want : predicted);
	endtask

	// Drop valid and hold until every outstanding result is back.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		wait (outcome_q.size() == 0);
	endtask

	task automatic write_clock_rule(input logic value);
		drain();
		repeat (SETTLE_TICKS) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_SETUP_NEEDS_CLOCK_OK;
		pwdata  <= DataW'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		clock_rule = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Receiver side: random stall, changed on the falling edge.
	always @(negedge clk) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else
			res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			got = {power_state, converter_enable, clear_backend_faults,
				fpga_reset_pulse, quiesced_notify};
			if (outcome_q.size() == 0) begin
				report_mismatch("unexpected transaction, state",
					int'(got.power_state), 0);
			end else begin
				want = outcome_q.pop_front();
				if (got.power_state !== want.power_state)
					report_mismatch("power_state", int'(got.power_state),
						int'(want.power_state));
				if (got.converter_enable !== want.converter_enable)
					report_mismatch("converter_enable", int'(got.converter_enable),
						int'(want.converter_enable));
				if (got.clear_backend_faults !== want.clear_backend_faults)
					report_mismatch("clear_backend_faults",
						int'(got.clear_backend_faults),
						int'(want.clear_backend_faults));
				if (got.fpga_reset_pulse !== want.fpga_reset_pulse)
					report_mismatch("fpga_reset_pulse", int'(got.fpga_reset_pulse),
						int'(want.fpga_reset_pulse));
				if (got.quiesced_notify !== want.quiesced_notify)
					report_mismatch("quiesced_notify", int'(got.quiesced_notify),
						int'(want.quiesced_notify));
			end
			outcome_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		req_valid          = 1'b0;
		payload_power_good = 1'b0;
		converters_good    = 1'b0;
		cold_reset_event   = 1'b0;
		warm_reset_event   = 1'b0;
		quiesce_event      = 1'b0;
		clock_setup_ok     = 1'b0;
		seq_state          = ST_NONE;
		quiesce_held       = 1'b0;
		enable_held        = 1'b0;
		clock_rule         = 1'b1;
		pg_level           = 1'b1;
		dcdc_level         = 1'b1;
		send_idle_pct      = 25;
		recv_idle_pct      = 78;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i])
			send_tick(directed_plan[i].tick, directed_plan[i].typed, directed_plan[i].want);

		for (int phase = 0; phase < 4; phase++) begin
			write_clock_rule(phase[0]);
			case (phase)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 78;
				end
				1: begin
					send_idle_pct = 78;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_TICKS; n++) begin
				// hold the sender until the pipeline has emptied once
				if (phase == 1 && n == RANDOM_TICKS / 2)
					drain();
				send_tick(random_tick(), 1'b0, '0);
			end
		end

		drain();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
